>>> rtl/fse_pkg.sv
// shared constants, types and sine table generator for the string evaluator
package fse_pkg;

    localparam int unsigned MAX_HARMONICS_DEF   = 64;
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_DISP  = 2'd1,
        REQ_VEL   = 2'd2,
        REQ_SLOPE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        REG_NUM_HARM  = 2'd0,
        REG_TIME_STEP = 2'd1,
        REG_VEL_GAIN  = 2'd2,
        REG_SLOPE_GAIN = 2'd3
    } t_reg_idx;

    localparam logic [6:0]  NUM_HARM_RST   = 7'd0;
    localparam logic [31:0] TIME_STEP_RST  = 32'd0;
    localparam logic [31:0] VEL_GAIN_RST   = 32'd65536;
    localparam logic [31:0] SLOPE_GAIN_RST = 32'd65536;

    // first-quadrant sine in q1.15, taylor series evaluated at elaboration
    function automatic logic [15:0] quarter_sine(input int unsigned k, input int unsigned b);
        logic [63:0]        theta;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        theta = (64'(k) * 64'd1686629713) >> (b - 2);
        t2    = (theta * theta) >> 30;
        term  = theta;
        acc   = signed'(theta);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = 64'sd0;
        end
        acc = (acc + 64'sd16384) >>> 15;
        if (acc > 64'sd32767) begin
            acc = 64'sd32767;
        end
        return acc[15:0];
    endfunction

endpackage

>>> rtl/fourier_series_string_eval.sv
// Vibrating-string evaluator: a load beat stores one harmonic's cosine and sine weights in a
// ram and returns its result from S_OUT through the output register; an evaluate beat walks
// harmonics 1..count through a shared five-stage term pipeline, one harmonic issued per cycle,
// where count is num_harmonics capped at MAX_HARMONICS. An evaluate beat steps through
// S_SETUP, S_RUN (harmonic issue and pipeline drain), S_FIN and S_OUT for displacement, and
// through S_MAG, S_SCLLO and S_SCLHI (the two-pass gain multiply) before S_FIN for velocity or
// slope; the next beat is taken once S_OUT is left. Zero harmonics skip the drain. A result
// left waiting on the output holds off the next beat. The block takes one beat at a time.
module fourier_series_string_eval
    import fse_pkg::*;
#(
    parameter int unsigned MAX_HARMONICS   = fse_pkg::MAX_HARMONICS_DEF,
    parameter int unsigned SINE_TABLE_BITS = fse_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fse_pkg::ADDR_W-1:0]  paddr,
    input  logic [fse_pkg::DATA_W-1:0]  pwdata,
    output logic [fse_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [5:0]                  i_harmonic_index,
    input  logic signed [31:0]          i_cos_weight,
    input  logic signed [31:0]          i_sin_weight,
    input  logic [15:0]                 i_position,
    input  logic [31:0]                 i_time_tick,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [31:0]          o_value,
    output logic                        o_status
);

    localparam int unsigned AW   = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int unsigned IW   = $clog2(MAX_HARMONICS + 1);
    localparam int unsigned QB   = SINE_TABLE_BITS - 2;
    localparam int unsigned QLEN = 1 << QB;
    localparam int unsigned TW   = 36 + IW;
    localparam int unsigned SW   = TW + IW;
    localparam int unsigned HW   = (SW + 1) / 2;
    localparam int unsigned PW   = 2 * HW + 32;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SETUP = 8'b0000_0010,
        S_RUN   = 8'b0000_0100,
        S_MAG   = 8'b0000_1000,
        S_SCLLO = 8'b0001_0000,
        S_SCLHI = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [6:0]  r_num_harm;
    logic [31:0] r_time_step, r_vel_gain, r_slope_gain;

    t_req         r_req;
    logic [15:0]  r_pos;
    logic [31:0]  r_tick, r_tstep, r_pt, r_px;
    logic [IW-1:0] r_idx, r_left;
    logic [4:0]   r_pv;

    logic signed [15:0] r1_a, r1_b, r1_x;
    logic [IW-1:0]      r1_i, r2_i, r3_i, r4_i;
    logic signed [47:0] r2_p1, r2_p2;
    logic signed [15:0] r2_x, r3_x;
    logic signed [48:0] r3_tf;
    logic signed [64:0] r4_prod;
    logic signed [TW-1:0] r5_term;
    logic signed [SW-1:0] r_sum;
    logic [SW-1:0]        r_mag;
    logic [HW+31:0]       r_pp_lo, r_pp_hi;

    logic        r_res_status;
    logic [31:0] r_res_value;
    logic        r_out_valid, r_out_status;
    logic [31:0] r_out_value;

    // configuration port
    logic     w_cfg_we;
    t_reg_idx w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_we  = psel & penable & pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (w_cfg_idx)
            REG_NUM_HARM:   prdata = {25'd0, r_num_harm};
            REG_TIME_STEP:  prdata = r_time_step;
            REG_VEL_GAIN:   prdata = r_vel_gain;
            REG_SLOPE_GAIN: prdata = r_slope_gain;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_harm   <= NUM_HARM_RST;
            r_time_step  <= TIME_STEP_RST;
            r_vel_gain   <= VEL_GAIN_RST;
            r_slope_gain <= SLOPE_GAIN_RST;
        end else if (w_cfg_we) begin
            unique case (w_cfg_idx)
                REG_NUM_HARM:   r_num_harm   <= pwdata[6:0];
                REG_TIME_STEP:  r_time_step  <= pwdata;
                REG_VEL_GAIN:   r_vel_gain   <= pwdata;
                REG_SLOPE_GAIN: r_slope_gain <= pwdata;
                default: ;
            endcase
        end
    end

    // input handshake and coefficient ram
    logic          w_accept, w_is_load, w_idx_ok, w_we, w_issue;
    logic [IW-1:0] w_count;
    logic [63:0]   w_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_is_load  = (t_req'(i_req_type) == REQ_LOAD);
    assign w_idx_ok   = (32'(i_harmonic_index) < 32'(MAX_HARMONICS));
    assign w_we       = w_accept & w_is_load & w_idx_ok;
    assign w_issue    = (r_state == S_RUN) && (r_left != '0);
    assign w_count    = (32'(r_num_harm) > 32'(MAX_HARMONICS)) ? IW'(MAX_HARMONICS)
                                                              : IW'(r_num_harm);

    fse_ram #(
        .WIDTH (64),
        .DEPTH (MAX_HARMONICS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_harmonic_index)),
        .i_wdata ({i_cos_weight, i_sin_weight}),
        .i_raddr (AW'(r_idx - 1'b1)),
        .o_rdata (w_rdata)
    );

    // quarter-wave sine table
    logic [15:0] w_qtab [QLEN+1];

    for (genvar k = 0; k <= QLEN; k++) begin : g_qtab
        localparam logic [15:0] QV = quarter_sine(k, SINE_TABLE_BITS);
        assign w_qtab[k] = QV;
    end

    // phases of the harmonic being issued
    logic [31:0]        w_pt, w_px;
    logic [31:0]        w_ph [3];
    logic signed [15:0] w_rv [3];

    assign w_pt    = r_pt + r_tstep;
    assign w_px    = r_px + {r_pos, 15'd0};
    assign w_ph[0] = w_pt;
    assign w_ph[1] = w_pt + 32'h4000_0000;
    assign w_ph[2] = (r_req == REQ_SLOPE) ? (w_px + 32'h4000_0000) : w_px;

    for (genvar g = 0; g < 3; g++) begin : g_look
        logic [SINE_TABLE_BITS-1:0] w_tidx;
        logic [QB:0]                w_qi;
        logic signed [15:0]         w_mag;
        assign w_tidx = w_ph[g][31 -: SINE_TABLE_BITS];
        assign w_qi   = w_tidx[QB] ? ((QB+1)'(QLEN) - {1'b0, w_tidx[QB-1:0]})
                                   : {1'b0, w_tidx[QB-1:0]};
        assign w_mag  = signed'(w_qtab[w_qi]);
        assign w_rv[g] = w_tidx[QB+1] ? -w_mag : w_mag;
    end

    // term pipeline datapath
    logic signed [31:0]   w_c, w_s;
    logic signed [34:0]   w_shr;
    logic signed [IW:0]   w_mult;
    logic                 w_vel;

    assign w_c    = signed'(w_rdata[63:32]);
    assign w_s    = signed'(w_rdata[31:0]);
    assign w_vel  = (r_req == REQ_VEL);
    assign w_shr  = r4_prod[64:30];
    assign w_mult = (r_req == REQ_DISP) ? (IW+1)'(1) : signed'({1'b0, r4_i});

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r1_a <= w_vel ? -w_rv[0] : w_rv[1];
            r1_b <= w_vel ? w_rv[1] : w_rv[0];
            r1_x <= w_rv[2];
            r1_i <= r_idx;
        end
        r2_p1   <= w_c * r1_a;
        r2_p2   <= w_s * r1_b;
        r2_x    <= r1_x;
        r2_i    <= r1_i;
        r3_tf   <= 49'(r2_p1) + 49'(r2_p2);
        r3_x    <= r2_x;
        r3_i    <= r2_i;
        r4_prod <= r3_tf * r3_x;
        r4_i    <= r3_i;
        r5_term <= TW'(w_shr) * TW'(w_mult);
    end

    // gain scaling and saturation
    logic [HW-1:0]  w_mul_a;
    logic [31:0]    w_gain;
    logic [HW+31:0] w_mul;
    logic [PW-1:0]  w_prod;
    logic [31:0]    w_res, w_scaled, w_sat;
    logic [SW-32:0] w_top;

    assign w_mul_a  = (r_state == S_SCLHI) ? HW'(r_mag >> HW) : r_mag[HW-1:0];
    assign w_gain   = (r_req == REQ_SLOPE) ? r_slope_gain : r_vel_gain;
    assign w_mul    = w_mul_a * w_gain;
    assign w_prod   = PW'(r_pp_lo) + (PW'(r_pp_hi) << HW);
    assign w_res    = (|w_prod[PW-1:47]) ? 32'h8000_0000 : {1'b0, w_prod[46:16]};
    assign w_scaled = r_sum[SW-1] ? (32'd0 - w_res)
                    : ((w_res == 32'h8000_0000) ? 32'h7FFF_FFFF : w_res);
    assign w_top    = r_sum[SW-1:31];
    assign w_sat    = ((&w_top) | ~(|w_top)) ? r_sum[31:0]
                    : (r_sum[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = w_is_load ? S_OUT : S_SETUP;
            S_SETUP: n_state = S_RUN;
            S_RUN: begin
                if ((r_left == '0) && (r_pv == '0)) begin
                    n_state = (r_req == REQ_DISP) ? S_FIN : S_MAG;
                end
            end
            S_MAG:   n_state = S_SCLLO;
            S_SCLLO: n_state = S_SCLHI;
            S_SCLHI: n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= {r_pv[3:0], w_issue};
            if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req        <= t_req'(i_req_type);
            r_pos        <= i_position;
            r_tick       <= i_time_tick;
            r_res_value  <= '0;
            r_res_status <= w_is_load & ~w_idx_ok;
        end
        if (r_state == S_SETUP) begin
            r_tstep <= 32'(r_tick * r_time_step);
            r_pt    <= '0;
            r_px    <= '0;
            r_idx   <= IW'(1);
            r_left  <= w_count;
            r_sum   <= '0;
        end
        if (w_issue) begin
            r_pt   <= w_pt;
            r_px   <= w_px;
            r_idx  <= r_idx + 1'b1;
            r_left <= r_left - 1'b1;
        end
        if (r_pv[4]) begin
            r_sum <= r_sum + SW'(r5_term);
        end
        if (r_state == S_MAG) begin
            r_mag <= r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        end
        if (r_state == S_SCLLO) begin
            r_pp_lo <= w_mul;
        end
        if (r_state == S_SCLHI) begin
            r_pp_hi <= w_mul;
        end
        if (r_state == S_FIN) begin
            r_res_value <= (r_req == REQ_DISP) ? w_sat : w_scaled;
        end
        if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = signed'(r_out_value);
    assign o_status    = r_out_status;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");

    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_pv == '0)) else $error("ready while term pipeline busy");

    a_pipe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv != '0) |-> (r_state == S_RUN)) else $error("pipeline active outside run");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (32'(r_idx) <= 32'(MAX_HARMONICS))) else $error("harmonic past table");

    a_setup_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_load) |=> (r_state == S_SETUP)) else $error("evaluate not started");

endmodule

>>> rtl/fse_ram.sv
// generic single-write, single-read ram with registered read data
module fse_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
